FILE: rtl/mbrot_pkg.sv
// Shared constants and types for the Mandelbrot escape-time block.
package mbrot_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 28;
  localparam int WIDE_W    = 2 * DATA_W;
  localparam int CNT_W     = 16;
  localparam int SLOTS     = 4;
  localparam int TAG_W     = $clog2(SLOTS);

  localparam logic [CNT_W-1:0]  LIMIT_RESET = CNT_W'(10000);
  localparam logic [TAG_W:0]    SLOTS_CNT   = (TAG_W + 1)'(SLOTS);
  localparam logic [WIDE_W-1:0] ESC_LIMIT   = WIDE_W'(1) << (2 * FRAC_BITS + 2);

  typedef logic signed [DATA_W-1:0] fix_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    fix_t             c_real;
    fix_t             c_imag;
  } enter_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic             in_set;
  } done_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    fix_t             c_real;
    fix_t             c_imag;
    logic [CNT_W-1:0] cnt;
    logic             zero_lim;
  } ctx_t;

endpackage

FILE: rtl/mbrot_in_if.sv
// Input channel carrying one complex point per beat.
interface mbrot_in_if;
  logic                 valid;
  logic                 ready;
  mbrot_pkg::fix_t      c_real;
  mbrot_pkg::fix_t      c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

FILE: rtl/mbrot_out_if.sv
// Output channel carrying one in-set flag per beat.
interface mbrot_out_if;
  logic valid;
  logic ready;
  logic in_set;

  modport source (output valid, output in_set, input ready);
  modport sink   (input valid, input in_set, output ready);
endinterface

FILE: rtl/mbrot_iter.sv
// Four-stage recirculating iteration pipeline for z = z*z + c.
module mbrot_iter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [mbrot_pkg::CNT_W-1:0]    limit_i,
  input  mbrot_pkg::enter_t              enter_i,
  output logic                           enter_ok_o,
  output mbrot_pkg::done_t               done_o
);

  logic               s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  mbrot_pkg::ctx_t    ent_ctx, s1_ctx_q, s2_ctx_q, s3_ctx_q, s4_ctx_q;
  mbrot_pkg::fix_t    ent_zr, ent_zi;
  mbrot_pkg::wide_t   rr_d, ii_d, ri_d, s1_rr_q, s1_ii_q, s1_ri_q;
  mbrot_pkg::wide_t   diff, nr_w, ni_w, cr_ext, ci_ext;
  mbrot_pkg::fix_t    s2_nr_q, s2_ni_q, s3_nr_q, s3_ni_q, s4_nr_q, s4_ni_q;
  logic               ovf_d, s2_ovf_q, s3_ovf_q, s4_ovf_q;
  mbrot_pkg::wide_t   sr_d, si_d, s3_sr_q, s3_si_q;
  logic [mbrot_pkg::WIDE_W-1:0] mag;
  logic               s4_esc_q;
  logic [mbrot_pkg::CNT_W:0]    cnt_inc;
  logic               finish, recirc;

  assign cnt_inc = {1'b0, s4_ctx_q.cnt} + (mbrot_pkg::CNT_W + 1)'(1);
  assign finish  = s4_ctx_q.zero_lim | s4_ovf_q | s4_esc_q
                 | (cnt_inc == {1'b0, limit_i});
  assign recirc  = s4_valid_q & ~finish;

  assign enter_ok_o    = ~recirc;
  assign done_o.valid  = s4_valid_q & finish;
  assign done_o.tag    = s4_ctx_q.tag;
  assign done_o.in_set = s4_ctx_q.zero_lim | ~(s4_ovf_q | s4_esc_q);

  always_comb begin
    ent_ctx = s4_ctx_q;
    ent_zr  = s4_nr_q;
    ent_zi  = s4_ni_q;
    if (recirc) begin
      ent_ctx.cnt = cnt_inc[mbrot_pkg::CNT_W-1:0];
    end else begin
      ent_ctx.tag      = enter_i.tag;
      ent_ctx.c_real   = enter_i.c_real;
      ent_ctx.c_imag   = enter_i.c_imag;
      ent_ctx.cnt      = '0;
      ent_ctx.zero_lim = (limit_i == '0);
      ent_zr           = '0;
      ent_zi           = '0;
    end
    rr_d = ent_zr * ent_zr;
    ii_d = ent_zi * ent_zi;
    ri_d = ent_zr * ent_zi;
  end

  always_comb begin
    cr_ext = {{(mbrot_pkg::WIDE_W - mbrot_pkg::DATA_W){s1_ctx_q.c_real[mbrot_pkg::DATA_W-1]}},
              s1_ctx_q.c_real};
    ci_ext = {{(mbrot_pkg::WIDE_W - mbrot_pkg::DATA_W){s1_ctx_q.c_imag[mbrot_pkg::DATA_W-1]}},
              s1_ctx_q.c_imag};
    diff   = s1_rr_q - s1_ii_q;
    nr_w   = (diff >>> mbrot_pkg::FRAC_BITS) + cr_ext;
    ni_w   = (s1_ri_q >>> (mbrot_pkg::FRAC_BITS - 1)) + ci_ext;
    ovf_d  = (nr_w[mbrot_pkg::WIDE_W-1:mbrot_pkg::DATA_W-1]
              != {(mbrot_pkg::WIDE_W - mbrot_pkg::DATA_W + 1){nr_w[mbrot_pkg::DATA_W-1]}})
           | (ni_w[mbrot_pkg::WIDE_W-1:mbrot_pkg::DATA_W-1]
              != {(mbrot_pkg::WIDE_W - mbrot_pkg::DATA_W + 1){ni_w[mbrot_pkg::DATA_W-1]}});
    sr_d   = s2_nr_q * s2_nr_q;
    si_d   = s2_ni_q * s2_ni_q;
    mag    = s3_sr_q + s3_si_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= recirc | enter_i.valid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ctx_q <= ent_ctx;
    s1_rr_q  <= rr_d;
    s1_ii_q  <= ii_d;
    s1_ri_q  <= ri_d;
    s2_ctx_q <= s1_ctx_q;
    s2_nr_q  <= nr_w[mbrot_pkg::DATA_W-1:0];
    s2_ni_q  <= ni_w[mbrot_pkg::DATA_W-1:0];
    s2_ovf_q <= ovf_d;
    s3_ctx_q <= s2_ctx_q;
    s3_nr_q  <= s2_nr_q;
    s3_ni_q  <= s2_ni_q;
    s3_ovf_q <= s2_ovf_q;
    s3_sr_q  <= sr_d;
    s3_si_q  <= si_d;
    s4_ctx_q <= s3_ctx_q;
    s4_nr_q  <= s3_nr_q;
    s4_ni_q  <= s3_ni_q;
    s4_ovf_q <= s3_ovf_q;
    s4_esc_q <= (mag > mbrot_pkg::ESC_LIMIT);
  end

endmodule

FILE: rtl/mandelbrot_escape_test_top.sv
// Top level of the Mandelbrot escape-time test with result reordering.
//
// Points arrive on pt_i as signed Q4.28 real and imaginary parts, one per
// beat, and each yields exactly one in_set beat on res_o, in arrival order.
// The iteration limit is written through cfg_we_i and cfg_wdata_i; the user
// must write it only while the block is idle, as the block does not enforce
// this. Zero means no iteration runs and the point is in the set.
// One iteration of z = z*z + c passes through a four-stage ring (products,
// rescale and add, squares, magnitude compare), so a point that runs n
// iterations passes through the ring n times, and its result is registered
// in the reorder buffer before it reaches res_o.
// A zero limit still makes one pass through the ring.
// Up to four points circulate interleaved, one per ring stage.
// Finished points wait in a four-entry reorder buffer until their turn.
// When res_o stalls, finished results stay in that buffer and pt_i drops
// ready once four points are outstanding; nothing is lost or repeated.
// The pt_i port also waits in any cycle where a circulating point takes the
// entry stage.
// Reset empties the ring and the buffer and restores the limit to 10000.
module mandelbrot_escape_test_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mbrot_pkg::CNT_W-1:0] cfg_wdata_i,
  mbrot_in_if.sink                    pt_i,
  mbrot_out_if.source                 res_o
);

  logic [mbrot_pkg::CNT_W-1:0] limit_q;
  logic [mbrot_pkg::TAG_W-1:0] tail_q, head_q;
  logic [mbrot_pkg::TAG_W:0]   cnt_q, cnt_d;
  logic [mbrot_pkg::SLOTS-1:0] rob_vld_q, rob_vld_d, rob_set_q;
  logic                        enter_ok, pt_fire, res_fire;
  mbrot_pkg::enter_t           enter;
  mbrot_pkg::done_t            done;

  assign pt_i.ready   = (cnt_q < mbrot_pkg::SLOTS_CNT) & enter_ok;
  assign pt_fire      = pt_i.valid & pt_i.ready;
  assign res_o.valid  = rob_vld_q[head_q];
  assign res_o.in_set = rob_set_q[head_q];
  assign res_fire     = res_o.valid & res_o.ready;

  assign enter.valid  = pt_fire;
  assign enter.tag    = tail_q;
  assign enter.c_real = pt_i.c_real;
  assign enter.c_imag = pt_i.c_imag;

  mbrot_iter u_iter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_i    (limit_q),
    .enter_i    (enter),
    .enter_ok_o (enter_ok),
    .done_o     (done)
  );

  always_comb begin
    cnt_d = cnt_q;
    if (pt_fire) begin
      cnt_d = cnt_d + (mbrot_pkg::TAG_W + 1)'(1);
    end
    if (res_fire) begin
      cnt_d = cnt_d - (mbrot_pkg::TAG_W + 1)'(1);
    end
  end

  always_comb begin
    rob_vld_d = rob_vld_q;
    if (res_fire) begin
      rob_vld_d[head_q] = 1'b0;
    end
    if (done.valid) begin
      rob_vld_d[done.tag] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= mbrot_pkg::LIMIT_RESET;
      tail_q    <= '0;
      head_q    <= '0;
      cnt_q     <= '0;
      rob_vld_q <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (pt_fire) begin
        tail_q <= tail_q + mbrot_pkg::TAG_W'(1);
      end
      if (res_fire) begin
        head_q <= head_q + mbrot_pkg::TAG_W'(1);
      end
      rob_vld_q <= rob_vld_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done.valid) begin
      rob_set_q[done.tag] <= done.in_set;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mbrot_pkg::SLOTS_CNT)
    else $error("Outstanding point count exceeds the ring size.");

  a_rob_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done.valid |-> !rob_vld_q[done.tag])
    else $error("A finished point overwrote a pending result.");

  a_out_owned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (cnt_q != '0))
    else $error("A result is offered with no point outstanding.");
`endif

endmodule
